// ===== hdl/crc_framed_packet_checker_assert.svh =====
// ----------------------------------------------------------------------------
// crc framed packet checker assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef CRC_FRAMED_PACKET_CHECKER_ASSERT_SVH
`define CRC_FRAMED_PACKET_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CFPC_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cfpc assertion failed");
`define CFPC_ASSERT(lbl, prop) `CFPC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define CFPC_ASSERT_CLK(lbl, clk, rstn, prop)
`define CFPC_ASSERT(lbl, prop)
`endif

`endif

// ===== hdl/cfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpc_pkg
// shared types, constants and crc byte functions of the framed packet checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfpc_pkg;

  localparam logic [15:0] Crc16Poly     = 16'hA001;
  localparam logic [15:0] Crc16Init     = 16'h3AA3;
  localparam logic [31:0] Crc32Poly     = 32'hEDB88320;
  localparam logic [31:0] Crc32Init     = 32'h00003AA3;
  localparam logic [15:0] MinFrameBytes = 16'd18;
  localparam logic [15:0] HdrCrcSpan    = 16'd10;
  localparam logic [15:0] CountMax      = 16'hFFFF;
  localparam logic [7:0]  StartReset    = 8'hAA;
  localparam logic [15:0] LenMaskReset  = 16'h03FF;

  localparam logic [15:0] PosStart   = 16'd0;
  localparam logic [15:0] PosLenLo   = 16'd1;
  localparam logic [15:0] PosLenHi   = 16'd2;
  localparam logic [15:0] PosBodyCrc = 16'd4;
  localparam logic [15:0] PosHcrcLo  = 16'd10;
  localparam logic [15:0] PosHcrcHi  = 16'd11;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_LEN       = 3'd3,
    ST_HDR_CRC   = 3'd4,
    ST_BODY_CRC  = 3'd5
  } cfpc_status_e;

  typedef enum logic [0:0] {
    REG_START_BYTE  = 1'b0,
    REG_LENGTH_MASK = 1'b1
  } cfpc_reg_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] length_mask;
  } cfpc_cfg_t;

  typedef struct packed {
    logic [15:0] count;
    logic        start_ok;
    logic [15:0] len_masked;
    logic [15:0] hcrc_run;
    logic [15:0] hcrc_field;
    logic [31:0] bcrc_run;
    logic [31:0] tail;
  } cfpc_snap_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc16Poly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc32Poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/cfpc_regs.sv =====
// ----------------------------------------------------------------------------
// cfpc_regs
// apb register file holding the start byte and the length mask
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfpc_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfpc_pkg::cfpc_cfg_t cfg_o
);

  cfpc_pkg::cfpc_cfg_t cfg_q, cfg_d;
  cfpc_pkg::cfpc_reg_e idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = cfpc_pkg::cfpc_reg_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        cfpc_pkg::REG_START_BYTE:  cfg_d.start_byte  = pwdata[7:0];
        cfpc_pkg::REG_LENGTH_MASK: cfg_d.length_mask = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cfpc_pkg::REG_START_BYTE:  prdata = {24'h000000, cfg_q.start_byte};
      cfpc_pkg::REG_LENGTH_MASK: prdata = {16'h0000, cfg_q.length_mask};
      default:                   prdata = 32'h00000000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= cfpc_pkg::StartReset;
      cfg_q.length_mask <= cfpc_pkg::LenMaskReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/cfpc_track.sv =====
// ----------------------------------------------------------------------------
// cfpc_track
// per-byte frame state with running crcs and the end-of-frame snapshot register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc_framed_packet_checker_assert.svh"

module cfpc_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfpc_pkg::cfpc_cfg_t  cfg_i,
  input  logic                 accept_i,
  input  logic [7:0]           data_i,
  input  logic                 last_i,
  input  logic                 take_i,
  output cfpc_pkg::cfpc_snap_t snap_o,
  output logic                 snap_vld_o
);

  logic [15:0] count_q, count_d;
  logic        start_ok_q, start_ok_d;
  logic [15:0] len_q, len_d;
  logic [15:0] hcrc_q, hcrc_d;
  logic [15:0] hfield_q, hfield_d;
  logic [31:0] bcrc_q, bcrc_d;
  logic [7:0]  tail_q [4];
  logic [7:0]  tail_d [4];
  logic        snap_vld_q, snap_vld_d;
  cfpc_pkg::cfpc_snap_t snap_q, snap_d;

  // next frame state for the byte in hand
  always_comb begin
    start_ok_d = start_ok_q;
    len_d      = len_q;
    hfield_d   = hfield_q;
    case (count_q)
      cfpc_pkg::PosStart:  start_ok_d     = (data_i == cfg_i.start_byte);
      cfpc_pkg::PosLenLo:  len_d[7:0]     = data_i;
      cfpc_pkg::PosLenHi:  len_d[15:8]    = data_i;
      cfpc_pkg::PosHcrcLo: hfield_d[7:0]  = data_i;
      cfpc_pkg::PosHcrcHi: hfield_d[15:8] = data_i;
      default: ;
    endcase
    hcrc_d = (count_q < cfpc_pkg::HdrCrcSpan) ? cfpc_pkg::crc16_byte(hcrc_q, data_i) : hcrc_q;
    bcrc_d = (count_q >= cfpc_pkg::PosBodyCrc) ? cfpc_pkg::crc32_byte(bcrc_q, tail_q[0])
                                                : bcrc_q;
    tail_d[0] = tail_q[1];
    tail_d[1] = tail_q[2];
    tail_d[2] = tail_q[3];
    tail_d[3] = data_i;
    count_d   = (count_q == cfpc_pkg::CountMax) ? count_q : count_q + 16'd1;

    snap_d.count      = count_d;
    snap_d.start_ok   = start_ok_d;
    snap_d.len_masked = len_d & cfg_i.length_mask;
    snap_d.hcrc_run   = hcrc_d;
    snap_d.hcrc_field = hfield_d;
    snap_d.bcrc_run   = bcrc_d;
    snap_d.tail       = {tail_d[3], tail_d[2], tail_d[1], tail_d[0]};

    snap_vld_d = snap_vld_q;
    if (accept_i && last_i) begin
      snap_vld_d = 1'b1;
    end else if (take_i) begin
      snap_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      start_ok_q <= 1'b0;
      len_q      <= '0;
      hcrc_q     <= cfpc_pkg::Crc16Init;
      hfield_q   <= '0;
      bcrc_q     <= cfpc_pkg::Crc32Init;
      for (int i = 0; i < 4; i++) begin
        tail_q[i] <= '0;
      end
      snap_vld_q <= 1'b0;
    end else begin
      snap_vld_q <= snap_vld_d;
      if (accept_i) begin
        if (last_i) begin
          count_q    <= '0;
          start_ok_q <= 1'b0;
          len_q      <= '0;
          hcrc_q     <= cfpc_pkg::Crc16Init;
          hfield_q   <= '0;
          bcrc_q     <= cfpc_pkg::Crc32Init;
          for (int i = 0; i < 4; i++) begin
            tail_q[i] <= '0;
          end
        end else begin
          count_q    <= count_d;
          start_ok_q <= start_ok_d;
          len_q      <= len_d;
          hcrc_q     <= hcrc_d;
          hfield_q   <= hfield_d;
          bcrc_q     <= bcrc_d;
          for (int i = 0; i < 4; i++) begin
            tail_q[i] <= tail_d[i];
          end
        end
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept_i && last_i) begin
      snap_q <= snap_d;
    end
  end

  assign snap_o     = snap_q;
  assign snap_vld_o = snap_vld_q;

  `CFPC_ASSERT(a_count_clears, accept_i && last_i |=> count_q == 16'd0)
  `CFPC_ASSERT(a_snap_holds, snap_vld_q && !take_i && !(accept_i && last_i) |=> snap_vld_q)
  `CFPC_ASSERT(a_no_overrun, snap_vld_q && !take_i |-> !(accept_i && last_i))
  `CFPC_ASSERT(a_take_valid, take_i |-> snap_vld_q)

endmodule

// ===== hdl/cfpc_verdict.sv =====
// ----------------------------------------------------------------------------
// cfpc_verdict
// ordered frame checks on the snapshot and the result output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfpc_verdict (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfpc_pkg::cfpc_snap_t snap_i,
  input  logic                 snap_vld_i,
  output logic                 take_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [23:0]          m_tdata_o
);

  cfpc_pkg::cfpc_status_e status;
  logic                   vld_q, vld_d;
  logic                   out_free;
  logic [23:0]            data_q;

  always_comb begin
    if (snap_i.count < cfpc_pkg::MinFrameBytes) begin
      status = cfpc_pkg::ST_SHORT;
    end else if (!snap_i.start_ok) begin
      status = cfpc_pkg::ST_BAD_START;
    end else if (snap_i.len_masked != snap_i.count) begin
      status = cfpc_pkg::ST_LEN;
    end else if (snap_i.hcrc_field != snap_i.hcrc_run) begin
      status = cfpc_pkg::ST_HDR_CRC;
    end else if (snap_i.tail != snap_i.bcrc_run) begin
      status = cfpc_pkg::ST_BODY_CRC;
    end else begin
      status = cfpc_pkg::ST_OK;
    end
  end

  assign out_free = !vld_q || m_tready_i;
  assign take_o   = snap_vld_i && out_free;

  always_comb begin
    vld_d = vld_q;
    if (take_o) begin
      vld_d = 1'b1;
    end else if (m_tready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      data_q <= {4'h0, snap_i.count, status == cfpc_pkg::ST_OK, status};
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = data_q;

endmodule

// ===== hdl/crc_framed_packet_checker.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_checker
// Checks received frames byte by byte and returns one verdict per frame.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle while the result side keeps up; the
// byte-wide CRC-32 update of the running body checksum sets the cycle. The
// verdict for a frame goes through the snapshot register of cfpc_track and the
// result register of cfpc_verdict; the next frame may start as the snapshot is
// handed on. When one verdict waits in the result register and a second one
// waits behind it, the input stalls until the result stream takes a verdict.
// Checks in priority order: at least 18 bytes, start byte, masked length
// field, header CRC-16 over bytes 0-9 against bytes 10-11, body CRC-32 over all
// bytes before the last four against the last four bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_framed_packet_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte[7:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // status[2:0], frame_ok[3], frame_length[19:4]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfpc_pkg::cfpc_cfg_t  cfg;
  cfpc_pkg::cfpc_snap_t snap;
  logic                 snap_vld;
  logic                 take;
  logic                 accept;

  assign s_axis_tready_o = !snap_vld || take;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  cfpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cfpc_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .data_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .take_i     (take),
    .snap_o     (snap),
    .snap_vld_o (snap_vld)
  );

  cfpc_verdict u_verdict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .snap_i     (snap),
    .snap_vld_i (snap_vld),
    .take_o     (take),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule
